### design/esfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped serial frame decoder package
// Shared constants, codes and types for the decoder's front end, byte queue
// and frame engine.
// ----------------------------------------------------------------------------
package esfd_pkg;

  // Framing bytes on the wire.
  localparam logic [7:0] HEADER_BYTE = 8'hE0;
  localparam logic [7:0] ESCAPE_BYTE = 8'hD0;

  // Addresses this node answers to.
  localparam logic [7:0] LOCAL_ADDR_0 = 8'h00;
  localparam logic [7:0] LOCAL_ADDR_1 = 8'h01;

  // Default depth of the queue between front end and frame engine.
  localparam int QUEUE_DEPTH = 4;

  // Frame engine phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  // Result kind codes.
  typedef enum logic [2:0] {
    KIND_BODY    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_HDR_ERR = 3'd2,
    KIND_LEN_ERR = 3'd3,
    KIND_SUM_ERR = 3'd4
  } kind_t;

  // Decoded byte request from the front end into the queue.
  typedef struct packed {
    logic       push;
    logic [7:0] data;
  } byte_req_t;

endpackage
`default_nettype wire

### design/escaped_serial_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped serial frame decoder
// Decodes byte-stuffed serial frames and reports body bytes and verdicts.
// ----------------------------------------------------------------------------
// The decoder takes one raw byte per cycle while in_stall is low: the front
// end strips escape codes into a small queue (QUEUE_DEPTH bytes), and the
// frame engine consumes one decoded byte per cycle into an output register
// unless out_stall holds a result there. With nothing waiting ahead of it, a
// frame's last raw byte is written into the queue, and its result is then
// loaded into the output register. Escape codes and the header and length
// bytes of a good frame give no result. in_stall rises only when the queue
// is full, which at the default depth follows only from out_stall.
// ----------------------------------------------------------------------------
module escaped_serial_frame_decoder #(
  parameter int QUEUE_DEPTH = esfd_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] raw_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      kind,
  output logic [7:0]      body_byte,
  output logic [7:0]      position,
  output logic [7:0]      address,
  output logic [7:0]      sequence_res,
  output logic [7:0]      command,
  output logic [7:0]      payload_length,
  output logic            accepted
);

  esfd_pkg::byte_req_t req;
  logic       queue_full;
  logic       q_valid;
  logic [7:0] q_data;
  logic       q_pop;

  // Unescaping front end.
  esfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_byte   (raw_byte),
    .queue_full (queue_full),
    .req        (req)
  );

  // Decoded byte queue.
  esfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .pop      (q_pop),
    .full     (queue_full),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // Frame engine and output register.
  esfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .body_byte      (body_byte),
    .position       (position),
    .address        (address),
    .sequence_res   (sequence_res),
    .command        (command),
    .payload_length (payload_length),
    .accepted       (accepted)
  );

endmodule
`default_nettype wire

### design/esfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped serial frame decoder front end
// Accepts raw serial bytes, drops escape codes and increments the byte that
// follows an escape, then pushes decoded bytes into the queue.
// ----------------------------------------------------------------------------
module esfd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         raw_byte,
  input  wire logic               queue_full,
  output esfd_pkg::byte_req_t     req
);

  logic escape_pending;
  logic escape_pending_next;
  logic accept;
  logic is_escape;

  // A request is taken whenever the queue has room.
  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign is_escape = (raw_byte == esfd_pkg::ESCAPE_BYTE);

  // Unescape: an escape code only marks the next byte; repeated codes collapse.
  always_comb begin
    escape_pending_next = escape_pending;
    req.push = 1'b0;
    req.data = escape_pending ? raw_byte + 8'd1 : raw_byte;
    if (accept) begin
      if (is_escape) begin
        escape_pending_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        req.push = 1'b1;
      end
    end
  end

  // Escape flag register.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule
`default_nettype wire

### design/esfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped serial frame decoder byte queue
// Small first-in first-out buffer that decouples the front end from the
// frame engine so that either side can stall on its own.
// ----------------------------------------------------------------------------
module esfd_queue #(
  parameter int DEPTH = esfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire esfd_pkg::byte_req_t req,
  input  wire logic                pop,
  output logic                     full,
  output logic                     rd_valid,
  output logic [7:0]               rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_ptr] <= req.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (req.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !req.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/esfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped serial frame decoder frame engine
// Walks decoded bytes through header, length, body and checksum phases and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module esfd_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire logic [7:0] q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      kind,
  output logic [7:0]      body_byte,
  output logic [7:0]      position,
  output logic [7:0]      address,
  output logic [7:0]      sequence_res,
  output logic [7:0]      command,
  output logic [7:0]      payload_length,
  output logic            accepted
);

  esfd_pkg::phase_t phase;
  esfd_pkg::phase_t phase_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;
  logic [7:0] body_count;
  logic [7:0] body_count_next;
  logic [7:0] held_address;
  logic [7:0] held_address_next;
  logic [7:0] held_sequence;
  logic [7:0] held_sequence_next;
  logic [7:0] held_command;
  logic [7:0] held_command_next;
  logic [7:0] held_payload_length;
  logic [7:0] held_payload_length_next;

  logic            res_valid;
  esfd_pkg::kind_t res_kind;
  logic [7:0]      res_body_byte;
  logic [7:0]      res_position;
  logic [7:0]      res_address;
  logic [7:0]      res_sequence;
  logic [7:0]      res_command;
  logic [7:0]      res_payload_length;
  logic            res_accepted;
  logic [7:0]      count_inc;

  // A byte is taken when the output register is free or drains this cycle.
  assign q_pop     = q_valid && (!out_valid || !out_stall);
  assign count_inc = body_count + 8'd1;

  // Next state and result for the byte at the head of the queue.
  always_comb begin
    phase_next               = phase;
    running_sum_next         = running_sum;
    frame_length_next        = frame_length;
    body_count_next          = body_count;
    held_address_next        = held_address;
    held_sequence_next       = held_sequence;
    held_command_next        = held_command;
    held_payload_length_next = held_payload_length;
    res_valid          = 1'b0;
    res_kind           = esfd_pkg::KIND_BODY;
    res_body_byte      = '0;
    res_position       = '0;
    res_address        = '0;
    res_sequence       = '0;
    res_command        = '0;
    res_payload_length = '0;
    res_accepted       = 1'b0;
    if (q_pop) begin
      unique case (phase)
        esfd_pkg::PH_HEADER: begin
          if (q_data != esfd_pkg::HEADER_BYTE) begin
            res_valid = 1'b1;
            res_kind  = esfd_pkg::KIND_HDR_ERR;
          end else begin
            phase_next = esfd_pkg::PH_LENGTH;
          end
        end
        esfd_pkg::PH_LENGTH: begin
          if (q_data == 8'd0) begin
            phase_next = esfd_pkg::PH_HEADER;
            res_valid  = 1'b1;
            res_kind   = esfd_pkg::KIND_LEN_ERR;
          end else begin
            frame_length_next        = q_data;
            running_sum_next         = q_data;
            body_count_next          = '0;
            held_address_next        = '0;
            held_sequence_next       = '0;
            held_command_next        = '0;
            held_payload_length_next = '0;
            phase_next = (q_data == 8'd1) ? esfd_pkg::PH_CHECK : esfd_pkg::PH_BODY;
          end
        end
        esfd_pkg::PH_BODY: begin
          body_count_next  = count_inc;
          running_sum_next = running_sum + q_data;
          case (count_inc)
            8'd1:    held_address_next        = q_data;
            8'd2:    held_sequence_next       = q_data;
            8'd3:    held_command_next        = q_data;
            8'd4:    held_payload_length_next = q_data;
            default: ;
          endcase
          // Last body byte once position + 1 reaches the frame length.
          if ({1'b0, count_inc} + 9'd1 >= {1'b0, frame_length}) begin
            phase_next = esfd_pkg::PH_CHECK;
          end
          res_valid     = 1'b1;
          res_kind      = esfd_pkg::KIND_BODY;
          res_body_byte = q_data;
          res_position  = count_inc;
        end
        esfd_pkg::PH_CHECK: begin
          phase_next         = esfd_pkg::PH_HEADER;
          res_valid          = 1'b1;
          res_address        = held_address;
          res_sequence       = held_sequence;
          res_command        = held_command;
          res_payload_length = held_payload_length;
          if (q_data == running_sum) begin
            res_kind     = esfd_pkg::KIND_GOOD;
            res_accepted = (held_address == esfd_pkg::LOCAL_ADDR_0) ||
                           (held_address == esfd_pkg::LOCAL_ADDR_1);
          end else begin
            res_kind = esfd_pkg::KIND_SUM_ERR;
          end
        end
        default: ;
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= esfd_pkg::PH_HEADER;
      running_sum         <= '0;
      frame_length        <= '0;
      body_count          <= '0;
      held_address        <= '0;
      held_sequence       <= '0;
      held_command        <= '0;
      held_payload_length <= '0;
    end else begin
      phase               <= phase_next;
      running_sum         <= running_sum_next;
      frame_length        <= frame_length_next;
      body_count          <= body_count_next;
      held_address        <= held_address_next;
      held_sequence       <= held_sequence_next;
      held_command        <= held_command_next;
      held_payload_length <= held_payload_length_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; it loads only when the register is free or drains this cycle.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      kind           <= res_kind;
      body_byte      <= res_body_byte;
      position       <= res_position;
      address        <= res_address;
      sequence_res   <= res_sequence;
      command        <= res_command;
      payload_length <= res_payload_length;
      accepted       <= res_accepted;
    end
  end

endmodule
`default_nettype wire
